[src/psgwd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psgwd_pkg
// Shared widths, register indexes, select codes and divider status type.
// ----------------------------------------------------------------------------
package psgwd_pkg;

	localparam int CFG_W   = 24;
	localparam int DIV_W   = 24;
	localparam int CNT_W   = 5;
	localparam int VOL_W   = 12;
	localparam int STEP_W  = 8;
	localparam int PER_W   = 10;
	localparam int CFGI_W  = 2;

	// configuration register indexes
	localparam logic [CFGI_W-1:0] CFG_MASTER_DIV   = 2'd0;
	localparam logic [CFGI_W-1:0] CFG_MASTER_CLOCK = 2'd1;
	localparam logic [CFGI_W-1:0] CFG_SAMPLE_RATE  = 2'd2;
	localparam logic [CFGI_W-1:0] CFG_VOLUME_STEP  = 2'd3;

	// configuration reset values
	localparam logic [CFG_W-1:0]  RST_MASTER_DIV   = 24'd111861;
	localparam logic [CFG_W-1:0]  RST_MASTER_CLOCK = 24'd3579545;
	localparam logic [CFG_W-1:0]  RST_SAMPLE_RATE  = 24'd16000;
	localparam logic [STEP_W-1:0] RST_VOLUME_STEP  = 8'd8;

	// register select codes
	localparam logic [2:0] SEL_NOISE_CTRL = 3'd6;

	// noise rate codes (control bits 1..0)
	localparam logic [1:0] NRATE_512  = 2'd0;
	localparam logic [1:0] NRATE_1024 = 2'd1;
	localparam logic [1:0] NRATE_2048 = 2'd2;
	localparam logic [1:0] NRATE_TONE = 2'd3;

	localparam logic [1:0] CH_NOISE = 2'd3;
	localparam logic [3:0] ATT_MAX  = 4'd15;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

[src/psgwd_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psgwd_div
// Restoring divider, one quotient bit per cycle; result held until acked.
// ----------------------------------------------------------------------------
module psgwd_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         ack,
	input  logic [psgwd_pkg::DIV_W-1:0]  dividend,
	input  logic [psgwd_pkg::DIV_W-1:0]  divisor,
	output psgwd_pkg::div_stat_t         stat,
	output logic [psgwd_pkg::DIV_W-1:0]  quotient
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]                      state_q;
	logic [psgwd_pkg::CNT_W-1:0]     cnt_q;
	logic [psgwd_pkg::DIV_W-1:0]     rem_q;
	logic [psgwd_pkg::DIV_W-1:0]     quo_q;
	logic [psgwd_pkg::DIV_W-1:0]     dvs_q;
	logic [psgwd_pkg::DIV_W:0]       trial;
	logic [psgwd_pkg::DIV_W:0]       diff;
	logic                            ge;

	assign trial = {rem_q, quo_q[psgwd_pkg::DIV_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == psgwd_pkg::CNT_W'(psgwd_pkg::DIV_W - 1))
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (ack)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath: quotient shifts in from the bottom as dividend bits leave the top
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (state_q == ST_RUN) begin
			rem_q <= ge ? diff[psgwd_pkg::DIV_W-1:0] : trial[psgwd_pkg::DIV_W-1:0];
			quo_q <= {quo_q[psgwd_pkg::DIV_W-2:0], ge};
		end
	end

	assign stat.busy = (state_q != ST_IDLE);
	assign stat.done = (state_q == ST_DONE);
	assign quotient  = quo_q;

endmodule

[src/psg_register_write_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_register_write_decoder
// Decodes sound chip register writes into per-channel volume/frequency beats.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / write_byte): one written byte a beat.
//   Latch bytes (bit 7 set) select a register and write its low data; data
//   bytes extend the latched tone period. A volume write or a completed tone
//   period yields one output beat (channel, volume, freq_valid, frequency).
//   Output channel (out_valid / out_stall): result held in an output register
//   until taken; a full output register does not block bytes that give no
//   result, but the next result waits in the divider until the slot frees.
//   Result path: a byte giving a result runs the 24 steps of the shared
//   restoring divider, then the quotient moves into the output register
//   and out_valid rises. Bytes that give no result are taken every cycle
//   while the divider is idle. While the divider is busy or holds a finished
//   quotient, in_stall is high, so the bit-serial divider paces result-bearing
//   bytes, and a stalled output register holds them back further.
//   Configuration (cfg_we / cfg_index / cfg_data) writes take effect at once;
//   write only while idle.
//   Reset (arst_n low) clears the latch, tone periods to 1, attenuations and
//   noise control to 0, config registers to their defaults, and out_valid.
// ----------------------------------------------------------------------------
module psg_register_write_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_we,
	input  logic [psgwd_pkg::CFGI_W-1:0]  cfg_index,
	input  logic [psgwd_pkg::CFG_W-1:0]   cfg_data,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    write_byte,
	// output channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    channel,
	output logic [psgwd_pkg::VOL_W-1:0]   volume,
	output logic                          freq_valid,
	output logic [psgwd_pkg::DIV_W-1:0]   frequency
);

	// configuration registers
	logic [psgwd_pkg::CFG_W-1:0]  master_div_q;
	logic [psgwd_pkg::CFG_W-1:0]  master_clock_q;
	logic [psgwd_pkg::CFG_W-1:0]  sample_rate_q;
	logic [psgwd_pkg::STEP_W-1:0] volume_step_q;

	// chip register state
	logic                         sel_valid_q;
	logic [2:0]                   sel_reg_q;
	logic [psgwd_pkg::PER_W-1:0]  period_q [3];
	logic [3:0]                   atten_q  [4];
	logic [2:0]                   noise_ctrl_q;

	// pending result fields, held while the divider runs
	logic [1:0]                   pend_ch_q;
	logic [psgwd_pkg::VOL_W-1:0]  pend_vol_q;
	logic                         pend_zero_q;

	// output register
	logic                         out_valid_q;
	logic [1:0]                   out_ch_q;
	logic [psgwd_pkg::VOL_W-1:0]  out_vol_q;
	logic                         out_fv_q;
	logic [psgwd_pkg::DIV_W-1:0]  out_freq_q;

	psgwd_pkg::div_stat_t         div_stat;
	logic [psgwd_pkg::DIV_W-1:0]  div_quo;
	logic                         div_ack;

	logic                         in_acc;
	logic                         is_latch;
	logic [2:0]                   reg_nxt;
	logic                         valid_nxt;
	logic [1:0]                   tsel;
	logic [psgwd_pkg::PER_W-1:0]  per_new;
	logic                         emit;
	logic [1:0]                   em_ch;
	logic [3:0]                   em_att;
	logic [psgwd_pkg::DIV_W-1:0]  em_div;
	logic [psgwd_pkg::DIV_W-1:0]  noise_div;
	logic [psgwd_pkg::VOL_W-1:0]  em_vol;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = div_stat.busy;
	assign is_latch = write_byte[7];
	assign reg_nxt  = is_latch ? write_byte[6:4] : sel_reg_q;
	assign valid_nxt = is_latch || sel_valid_q;
	assign tsel     = reg_nxt[2:1];
	assign per_new  = {write_byte[5:0], period_q[tsel][3:0]};

	// noise divisor from current control and tone C period
	always_comb begin
		if (noise_ctrl_q[2]) begin
			noise_div = sample_rate_q;
		end else begin
			case (noise_ctrl_q[1:0])
				psgwd_pkg::NRATE_512:  noise_div = master_clock_q >> 9;
				psgwd_pkg::NRATE_1024: noise_div = master_clock_q >> 10;
				psgwd_pkg::NRATE_2048: noise_div = master_clock_q >> 11;
				default:               noise_div = {{(psgwd_pkg::DIV_W-psgwd_pkg::PER_W){1'b0}},
				                                    period_q[2]};
			endcase
		end
	end

	// decide whether this byte yields a result, and with what inputs
	always_comb begin
		emit   = 1'b0;
		em_ch  = tsel;
		em_att = atten_q[tsel];
		em_div = {{(psgwd_pkg::DIV_W-psgwd_pkg::PER_W){1'b0}}, period_q[tsel]};
		if (valid_nxt) begin
			if (!reg_nxt[0]) begin
				if (reg_nxt != psgwd_pkg::SEL_NOISE_CTRL && !is_latch) begin
					emit   = 1'b1;
					em_div = {{(psgwd_pkg::DIV_W-psgwd_pkg::PER_W){1'b0}}, per_new};
				end
			end else if (is_latch) begin
				emit   = 1'b1;
				em_att = write_byte[3:0];
				if (tsel == psgwd_pkg::CH_NOISE)
					em_div = noise_div;
			end
		end
	end

	// (15 - attenuation) * step: 4 x 8 bits, fits 12
	assign em_vol = psgwd_pkg::VOL_W'(psgwd_pkg::ATT_MAX - em_att) *
	                psgwd_pkg::VOL_W'(volume_step_q);

	psgwd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_acc && emit),
		.ack      (div_ack),
		.dividend (master_div_q),
		.divisor  (em_div),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	// quotient moves out once the output slot is free or being taken
	assign div_ack = div_stat.done && (!out_valid_q || !out_stall);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_div_q   <= psgwd_pkg::RST_MASTER_DIV;
			master_clock_q <= psgwd_pkg::RST_MASTER_CLOCK;
			sample_rate_q  <= psgwd_pkg::RST_SAMPLE_RATE;
			volume_step_q  <= psgwd_pkg::RST_VOLUME_STEP;
		end else if (cfg_we) begin
			case (cfg_index)
				psgwd_pkg::CFG_MASTER_DIV:   master_div_q   <= cfg_data;
				psgwd_pkg::CFG_MASTER_CLOCK: master_clock_q <= cfg_data;
				psgwd_pkg::CFG_SAMPLE_RATE:  sample_rate_q  <= cfg_data;
				psgwd_pkg::CFG_VOLUME_STEP:  volume_step_q  <= cfg_data[psgwd_pkg::STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// chip register state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_valid_q  <= 1'b0;
			sel_reg_q    <= '0;
			noise_ctrl_q <= '0;
			for (int i = 0; i < 3; i++)
				period_q[i] <= psgwd_pkg::PER_W'(1);
			for (int i = 0; i < 4; i++)
				atten_q[i] <= '0;
		end else if (in_acc) begin
			sel_valid_q <= valid_nxt;
			sel_reg_q   <= reg_nxt;
			if (valid_nxt) begin
				if (!reg_nxt[0]) begin
					if (reg_nxt == psgwd_pkg::SEL_NOISE_CTRL) begin
						if (is_latch)
							noise_ctrl_q <= write_byte[2:0];
					end else if (is_latch) begin
						period_q[tsel][3:0] <= write_byte[3:0];
					end else begin
						period_q[tsel] <= per_new;
					end
				end else if (is_latch) begin
					atten_q[tsel] <= write_byte[3:0];
				end
			end
		end
	end

	// pending result fields
	always_ff @(posedge clk) begin
		if (in_acc && emit) begin
			pend_ch_q   <= em_ch;
			pend_vol_q  <= em_vol;
			pend_zero_q <= (em_div == '0);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (div_ack) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (div_ack) begin
			out_ch_q   <= pend_ch_q;
			out_vol_q  <= pend_vol_q;
			out_fv_q   <= !pend_zero_q;
			out_freq_q <= pend_zero_q ? '0 : div_quo;
		end
	end

	assign out_valid  = out_valid_q;
	assign channel    = out_ch_q;
	assign volume     = out_vol_q;
	assign freq_valid = out_fv_q;
	assign frequency  = out_freq_q;

endmodule

[src/psgwd_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psgwd_chk
// Port-level checks on the decoder, bound into the decoder module.
// ----------------------------------------------------------------------------
module psgwd_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [1:0]                    channel,
	input logic [psgwd_pkg::VOL_W-1:0]   volume,
	input logic                          freq_valid,
	input logic [psgwd_pkg::DIV_W-1:0]   frequency
);

	// stalled beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(channel) && $stable(volume)
		&& $stable(freq_valid) && $stable(frequency))
		else $error("output beat changed while stalled");

	// zero divisor gives zero frequency
	a_zero_freq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !freq_valid |-> frequency == '0)
		else $error("frequency nonzero with freq_valid low");

	// volume never exceeds 15 * 255
	a_vol_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> volume <= psgwd_pkg::VOL_W'(3825))
		else $error("volume out of range");

	// a new beat only follows a divider run, which stalls the input
	a_rose_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without divider run");

endmodule

bind psg_register_write_decoder psgwd_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.channel    (channel),
	.volume     (volume),
	.freq_valid (freq_valid),
	.frequency  (frequency)
);

[tb/psg_update_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_update_checker
// Follows accepted bytes and register writes, predicts each channel update
// beat and compares the beats taken from the output channel, field by field.
// ----------------------------------------------------------------------------
module psg_update_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [psgwd_pkg::CFGI_W-1:0]  cfg_index,
	input  logic [psgwd_pkg::CFG_W-1:0]   cfg_data,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [7:0]                    write_byte,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [1:0]                    channel,
	input  logic [psgwd_pkg::VOL_W-1:0]   volume,
	input  logic                          freq_valid,
	input  logic [psgwd_pkg::DIV_W-1:0]   frequency,
	output int unsigned                   mismatches,
	output int unsigned                   pending
);

	localparam logic [1:0] CH_TONE_C = 2'd2;

	typedef struct packed {
		logic [1:0]                  channel;
		logic [psgwd_pkg::VOL_W-1:0] volume;
		logic                        freq_valid;
		logic [psgwd_pkg::DIV_W-1:0] frequency;
	} update_t;

	// predictor copy of the configuration and chip state
	logic [psgwd_pkg::CFG_W-1:0]  mdiv, mclk, srate;
	logic [psgwd_pkg::STEP_W-1:0] vstep;
	logic                         latched;
	logic [2:0]                   sel_reg;
	logic [psgwd_pkg::PER_W-1:0]  period [3];
	logic [3:0]                   atten [4];
	logic [2:0]                   nctrl;

	update_t                      expected_updates [$];
	update_t                      got, want;
	logic [7:0]                   b;
	logic [1:0]                   idx;
	logic [psgwd_pkg::DIV_W-1:0]  noise_div;
	int unsigned                  errs;

	function automatic update_t channel_update(input logic [1:0] ch,
			input logic [psgwd_pkg::DIV_W-1:0] divisor);
		update_t u;
		u.channel = ch;
		u.volume  = psgwd_pkg::VOL_W'(psgwd_pkg::ATT_MAX - atten[ch]) *
			psgwd_pkg::VOL_W'(vstep);
		u.freq_valid = (divisor != '0);
		if (u.freq_valid)
			u.frequency = mdiv / divisor;
		else
			u.frequency = '0;
		return u;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mdiv    = psgwd_pkg::RST_MASTER_DIV;
			mclk    = psgwd_pkg::RST_MASTER_CLOCK;
			srate   = psgwd_pkg::RST_SAMPLE_RATE;
			vstep   = psgwd_pkg::RST_VOLUME_STEP;
			latched = 1'b0;
			sel_reg = '0;
			foreach (period[i])
				period[i] = psgwd_pkg::PER_W'(1);
			foreach (atten[i])
				atten[i] = '0;
			nctrl = '0;
			errs  = 0;
			expected_updates.delete();
			mismatches <= 0;
			pending    <= 0;
		end else begin
			// result side
			if (out_valid && !out_stall) begin
				got = '{channel, volume, freq_valid, frequency};
				if (expected_updates.size() == 0) begin
					$error("unexpected beat: channel %0d volume %0d", channel, volume);
					errs++;
				end else begin
					want = expected_updates.pop_front();
					if (got.channel !== want.channel) begin
						$error("channel: expected %0d, got %0d", want.channel, got.channel);
						errs++;
					end
					if (got.volume !== want.volume) begin
						$error("volume: expected %0d, got %0d", want.volume, got.volume);
						errs++;
					end
					if (got.freq_valid !== want.freq_valid) begin
						$error("freq_valid: expected %0d, got %0d",
							want.freq_valid, got.freq_valid);
						errs++;
					end
					if (got.frequency !== want.frequency) begin
						$error("frequency: expected %0d, got %0d",
							want.frequency, got.frequency);
						errs++;
					end
				end
			end

			if (cfg_we) begin
				case (cfg_index)
					psgwd_pkg::CFG_MASTER_DIV:   mdiv  = cfg_data;
					psgwd_pkg::CFG_MASTER_CLOCK: mclk  = cfg_data;
					psgwd_pkg::CFG_SAMPLE_RATE:  srate = cfg_data;
					psgwd_pkg::CFG_VOLUME_STEP:  vstep = cfg_data[psgwd_pkg::STEP_W-1:0];
					default: ;
				endcase
			end

			// byte side
			if (in_valid && !in_stall) begin
				b = write_byte;
				if (b[7]) begin
					sel_reg = b[6:4];
					latched = 1'b1;
				end
				idx = sel_reg[2:1];
				if (!latched) begin
					// data byte before any latch: dropped
				end else if (sel_reg == psgwd_pkg::SEL_NOISE_CTRL) begin
					if (b[7])
						nctrl = b[2:0];
				end else if (!sel_reg[0]) begin
					if (b[7])
						period[idx][3:0] = b[3:0];
					else begin
						period[idx][psgwd_pkg::PER_W-1:4] = b[5:0];
						expected_updates.push_back(channel_update(idx,
							psgwd_pkg::DIV_W'(period[idx])));
					end
				end else if (b[7]) begin
					atten[idx] = b[3:0];
					if (idx == psgwd_pkg::CH_NOISE) begin
						if (nctrl[2])
							noise_div = srate;
						else begin
							case (nctrl[1:0])
								psgwd_pkg::NRATE_512:  noise_div = mclk >> 9;
								psgwd_pkg::NRATE_1024: noise_div = mclk >> 10;
								psgwd_pkg::NRATE_2048: noise_div = mclk >> 11;
								default: noise_div = psgwd_pkg::DIV_W'(period[CH_TONE_C]);
							endcase
						end
						expected_updates.push_back(channel_update(psgwd_pkg::CH_NOISE,
							noise_div));
					end else
						expected_updates.push_back(channel_update(idx,
							psgwd_pkg::DIV_W'(period[idx])));
				end
			end

			mismatches <= errs;
			pending    <= expected_updates.size();
		end
	end

endmodule

[tb/psg_register_write_decoder_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_register_write_decoder_test
// Drives register write bytes into the decoder under several settings of the
// configuration registers, with bursty input and a wandering output
// stall. The update checker predicts every channel update and compares it.
// ----------------------------------------------------------------------------
module psg_register_write_decoder_test;

	// Slowest correct beat: a divider run, a long output stall and a sender
	// gap. About 1650 bytes fit many times over.
	localparam int LIMIT        = 1_000_000;
	// quiet time after the last expected beat; covers the divider latency
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_BYTES = 300;

	// register select codes, bits 6..4 of a latch byte
	localparam logic [2:0] SEL_TONE_A    = 3'd0;
	localparam logic [2:0] SEL_ATT_A     = 3'd1;
	localparam logic [2:0] SEL_TONE_B    = 3'd2;
	localparam logic [2:0] SEL_ATT_B     = 3'd3;
	localparam logic [2:0] SEL_TONE_C    = 3'd4;
	localparam logic [2:0] SEL_ATT_C     = 3'd5;
	localparam logic [2:0] SEL_ATT_NOISE = 3'd7;

	logic                          clk        = 1'b0;
	logic                          arst_n     = 1'b0;
	logic                          cfg_we     = 1'b0;
	logic [psgwd_pkg::CFGI_W-1:0]  cfg_index  = '0;
	logic [psgwd_pkg::CFG_W-1:0]   cfg_data   = '0;
	logic                          in_valid   = 1'b0;
	logic                          in_stall;
	logic [7:0]                    write_byte = '0;
	logic                          out_valid;
	logic                          out_stall  = 1'b0;
	logic [1:0]                    channel;
	logic [psgwd_pkg::VOL_W-1:0]   volume;
	logic                          freq_valid;
	logic [psgwd_pkg::DIV_W-1:0]   frequency;

	int unsigned        mismatches;
	int unsigned        pending_updates;

	// sender burst and receiver stall state
	int                 burst_left = 1;
	int                 stall_mode = 0;
	int                 mode_left  = 0;
	int                 cycle_count;

	psg_register_write_decoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.write_byte (write_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.channel    (channel),
		.volume     (volume),
		.freq_valid (freq_valid),
		.frequency  (frequency)
	);

	psg_update_checker update_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.write_byte (write_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.channel    (channel),
		.volume     (volume),
		.freq_valid (freq_valid),
		.frequency  (frequency),
		.mismatches (mismatches),
		.pending    (pending_updates)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Receiver: switches between free running, coin-toss stalls and long
	// stalls, so that stalls land on every phase of the divider as well as
	// on a full output register.
	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode = $urandom_range(2);
			mode_left  = $urandom_range(400, 50);
		end else
			mode_left--;
		case (stall_mode)
			0:       out_stall <= 1'b0;
			1:       out_stall <= 1'($urandom_range(1));
			default: out_stall <= ($urandom_range(15) != 0);
		endcase
	end

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("status: fail");
		$finish;
	end

	function automatic logic [7:0] latch_byte(input logic [2:0] sel, input logic [3:0] data);
		return {1'b1, sel, data};
	endfunction

	// One beat on the input channel. Valid goes low only between bursts, never
	// in reaction to the stall, and the payload holds while stalled.
	task automatic send_byte(input logic [7:0] value);
		int gap;
		in_valid   <= 1'b1;
		write_byte <= value;
		do
			@(posedge clk);
		while (in_stall);
		burst_left--;
		if (burst_left <= 0) begin
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(7) == 0) ? $urandom_range(60, 20)
				: $urandom_range(16, 1);
		end
	endtask

	// Idle the input and wait until every predicted update has come out.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_updates != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [psgwd_pkg::CFGI_W-1:0] idx,
			input logic [psgwd_pkg::CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	task automatic configure(input logic [psgwd_pkg::CFG_W-1:0] md,
			input logic [psgwd_pkg::CFG_W-1:0] mc,
			input logic [psgwd_pkg::CFG_W-1:0] sr,
			input logic [psgwd_pkg::STEP_W-1:0] vs);
		write_reg(psgwd_pkg::CFG_MASTER_DIV,   md);
		write_reg(psgwd_pkg::CFG_MASTER_CLOCK, mc);
		write_reg(psgwd_pkg::CFG_SAMPLE_RATE,  sr);
		write_reg(psgwd_pkg::CFG_VOLUME_STEP,  psgwd_pkg::CFG_W'(vs));
		cfg_we <= 1'b0;
	endtask

	// Mostly well-formed writes: a tone latch followed by period bytes, volume
	// latches and noise control latches. The rest is raw noise bytes. Only the
	// bytes that matter count toward n.
	task automatic random_bytes(input int n);
		int         done;
		int         pick;
		int         k;
		logic [2:0] sel;
		logic [5:0] hi;
		done = 0;
		while (done < n) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				sel = 3'(2 * $urandom_range(2));
				send_byte(latch_byte(sel, ($urandom_range(7) == 0) ? 4'h0
					: 4'($urandom_range(15))));
				k = $urandom_range(3, 1);
				repeat (k) begin
					// zero high bits now and then, for a zero period
					hi = ($urandom_range(7) == 0) ? 6'h00 : 6'($urandom_range(63));
					send_byte({1'b0, 1'($urandom_range(1)), hi});
				end
				done += 1 + k;
			end else if (pick < 75) begin
				sel = {2'($urandom_range(3)), 1'b1};
				send_byte(latch_byte(sel, 4'($urandom_range(15))));
				done++;
			end else if (pick < 85) begin
				send_byte(latch_byte(psgwd_pkg::SEL_NOISE_CTRL, 4'($urandom_range(15))));
				done++;
			end else
				send_byte(8'($urandom_range(255)));
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, reset settings of the registers.
		// data bytes with no latch yet are dropped
		send_byte(8'h3F);
		send_byte(8'h40);
		// noise control latch gives no beat; a data byte after it is dropped
		send_byte(latch_byte(psgwd_pkg::SEL_NOISE_CTRL, {2'b00, psgwd_pkg::NRATE_512}));
		send_byte(8'h7F);
		send_byte(latch_byte(SEL_ATT_NOISE, 4'h0));
		// full attenuation, then a data byte with a volume latched is dropped
		send_byte(latch_byte(SEL_ATT_A, 4'hF));
		send_byte(8'h2A);
		// tone latch alone gives no beat; largest period, bit 6 ignored
		send_byte(latch_byte(SEL_TONE_A, 4'hF));
		send_byte(8'h3F);
		send_byte(8'h7F);
		// zero period on B and C: divisor zero
		send_byte(latch_byte(SEL_TONE_B, 4'h0));
		send_byte(8'h00);
		send_byte(latch_byte(SEL_ATT_B, 4'h7));
		send_byte(latch_byte(SEL_TONE_C, 4'h0));
		send_byte(8'h00);
		// noise clocked from tone C, first at zero period, then not
		send_byte(latch_byte(psgwd_pkg::SEL_NOISE_CTRL, {2'b00, psgwd_pkg::NRATE_TONE}));
		send_byte(latch_byte(SEL_ATT_NOISE, 4'h3));
		send_byte(latch_byte(SEL_TONE_C, 4'h1));
		send_byte(8'h10);
		send_byte(latch_byte(SEL_ATT_NOISE, 4'hC));
		// remaining fixed rates, then sample rate with bit 3 set and ignored
		send_byte(latch_byte(psgwd_pkg::SEL_NOISE_CTRL, {2'b00, psgwd_pkg::NRATE_1024}));
		send_byte(latch_byte(SEL_ATT_NOISE, 4'h5));
		send_byte(latch_byte(psgwd_pkg::SEL_NOISE_CTRL, {2'b00, psgwd_pkg::NRATE_2048}));
		send_byte(latch_byte(SEL_ATT_NOISE, 4'hA));
		send_byte(latch_byte(psgwd_pkg::SEL_NOISE_CTRL, 4'hF));
		send_byte(latch_byte(SEL_ATT_NOISE, 4'h1));
		send_byte(latch_byte(SEL_ATT_C, 4'h8));

		// random stretches under several register settings
		random_bytes(RANDOM_BYTES);
		drain();

		// every register at its maximum
		configure('1, '1, '1, '1);
		random_bytes(RANDOM_BYTES);
		drain();

		// every register zero: fixed rates and sample rate give zero divisors
		configure('0, '0, '0, '0);
		random_bytes(RANDOM_BYTES);
		drain();

		configure(psgwd_pkg::CFG_W'($urandom), psgwd_pkg::CFG_W'($urandom),
			psgwd_pkg::CFG_W'($urandom), psgwd_pkg::STEP_W'($urandom));
		random_bytes(RANDOM_BYTES);
		drain();

		// small clock and sample rate, so the noise divisor is often zero
		configure(psgwd_pkg::CFG_W'($urandom), psgwd_pkg::CFG_W'($urandom_range(4095)),
			psgwd_pkg::CFG_W'($urandom_range(3)), psgwd_pkg::STEP_W'($urandom));
		random_bytes(RANDOM_BYTES);
		drain();

		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
